[rtl/stunp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN parser package
// Shared constants, event codes and the result record of the STUN message
// parser.
// ----------------------------------------------------------------------------
package stunp_pkg;

  localparam logic [31:0] MAGIC_COOKIE = 32'h2112A442;
  localparam logic [15:0] CLASS_MASK   = 16'h0110;

  localparam logic [15:0] ATTR_MAPPED     = 16'h0001;
  localparam logic [15:0] ATTR_RESPONSE   = 16'h0002;
  localparam logic [15:0] ATTR_SOURCE     = 16'h0004;
  localparam logic [15:0] ATTR_CHANGED    = 16'h0005;
  localparam logic [15:0] ATTR_XOR_MAPPED = 16'h8020;

  localparam logic [2:0] KIND_MAPPED     = 3'd0;
  localparam logic [2:0] KIND_RESPONSE   = 3'd1;
  localparam logic [2:0] KIND_SOURCE     = 3'd2;
  localparam logic [2:0] KIND_CHANGED    = 3'd3;
  localparam logic [2:0] KIND_XOR_MAPPED = 3'd4;

  localparam logic [1:0] EV_HEADER     = 2'd0;
  localparam logic [1:0] EV_BAD_COOKIE = 2'd1;
  localparam logic [1:0] EV_ADDRESS    = 2'd2;
  localparam logic [1:0] EV_OTHER      = 2'd3;

  localparam int DATA_W = 120;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [15:0] msg_method;
    logic [1:0]  msg_class;
    logic [15:0] msg_length;
    logic [15:0] attr_type;
    logic [15:0] attr_length;
    logic [2:0]  addr_kind;
    logic        family_ipv4;
    logic [15:0] port;
    logic [31:0] ip_address;
    logic        message_done;
  } res_t;

endpackage

[rtl/stun_message_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN message parser
// Parses a STUN message byte stream: header, magic cookie check and the
// attribute walk, with address attributes decoded.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  s_axis   in         tdata: data_byte; tuser: start_req
//  m_axis   out        tdata: parsed fields; tuser: event_res; tlast: message_done
//
// One byte is taken per cycle unless a waiting result stalls it; a byte waits
// in the input register, and its result goes to the result register. Reset
// returns the parser to idle, waiting for a start byte. A waiting result stalls
// only bytes that would produce another result; the input register holds it.
// ----------------------------------------------------------------------------
module stun_message_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0]                    s_axis_tuser,  // [0] start_req
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] msg_method, [17:16] msg_class, [33:18] msg_length,
  // [49:34] attr_type, [65:50] attr_length, [68:66] addr_kind,
  // [69] family_ipv4, [85:70] port, [117:86] ip_address, [119:118] zero
  output logic [stunp_pkg::DATA_W-1:0]  m_axis_tdata,
  output logic [1:0]                    m_axis_tuser,  // [1:0] event_res
  output logic                          m_axis_tlast   // message_done
);

  logic            in_valid;
  logic [7:0]      in_byte;
  logic            in_start;
  logic            out_valid;
  stunp_pkg::res_t out_res;
  logic            has_res;
  stunp_pkg::res_t res;
  logic            out_free;
  logic            fire;

  assign out_free      = !out_valid || m_axis_tready;
  assign fire          = in_valid && (!has_res || out_free);
  assign s_axis_tready = !in_valid || fire;

  stunp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (fire),
    .data_byte (in_byte),
    .start_req (in_start),
    .has_res   (has_res),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && has_res) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_res) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.event_res;
  assign m_axis_tlast  = out_res.message_done;
  assign m_axis_tdata  = {2'b00, out_res.ip_address, out_res.port, out_res.family_ipv4,
                          out_res.addr_kind, out_res.attr_length, out_res.attr_type,
                          out_res.msg_length, out_res.msg_class, out_res.msg_method};

endmodule

[rtl/stunp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN parser core
// Holds the parse state and turns one message byte into a state update and at
// most one result.
// ----------------------------------------------------------------------------
module stunp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              start_req,
  output logic              has_res,
  output stunp_pkg::res_t   res
);

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_HEADER    = 2'd1;
  localparam logic [1:0] PH_ATTR_HDR  = 2'd2;
  localparam logic [1:0] PH_ATTR_BODY = 2'd3;

  localparam logic [16:0] CONSUMED_MAX = 17'h1FFFF;

  logic [1:0]  phase, phase_next;
  logic [4:0]  header_pos, header_pos_next;
  logic [15:0] header_type, header_type_next;
  logic [15:0] header_length, header_length_next;
  logic [31:0] cookie_shift, cookie_shift_next;
  logic [16:0] body_consumed, body_consumed_next;
  logic [15:0] cur_attr_type, cur_attr_type_next;
  logic [15:0] cur_attr_length, cur_attr_length_next;
  logic [16:0] attr_byte_index, attr_byte_index_next;
  logic [15:0] addr_family, addr_family_next;
  logic [15:0] addr_port, addr_port_next;
  logic [31:0] addr_ip, addr_ip_next;

  always_comb begin
    logic        fin;
    logic        is_addr;
    logic        done;
    logic [2:0]  kind;
    logic [16:0] padded;
    logic [17:0] idx_inc;

    phase_next           = phase;
    header_pos_next      = header_pos;
    header_type_next     = header_type;
    header_length_next   = header_length;
    cookie_shift_next    = cookie_shift;
    body_consumed_next   = body_consumed;
    cur_attr_type_next   = cur_attr_type;
    cur_attr_length_next = cur_attr_length;
    attr_byte_index_next = attr_byte_index;
    addr_family_next     = addr_family;
    addr_port_next       = addr_port;
    addr_ip_next         = addr_ip;
    fin     = 1'b0;
    is_addr = 1'b0;
    done    = 1'b0;
    kind    = stunp_pkg::KIND_MAPPED;
    padded  = ({1'b0, cur_attr_length} + 17'd3) & ~17'd3;
    idx_inc = {1'b0, attr_byte_index} + 18'd1;
    has_res = 1'b0;
    res     = '0;

    if (start_req) begin
      phase_next         = PH_HEADER;
      header_pos_next    = '0;
      header_type_next   = '0;
      header_length_next = '0;
      cookie_shift_next  = '0;
      body_consumed_next = '0;
    end

    if ((phase_next == PH_ATTR_HDR || phase_next == PH_ATTR_BODY) &&
        body_consumed_next != CONSUMED_MAX) begin
      body_consumed_next = body_consumed_next + 17'd1;
    end

    case (phase_next)
      PH_HEADER: begin
        if (header_pos_next < 5'd2) begin
          header_type_next = {header_type_next[7:0], data_byte};
        end else if (header_pos_next < 5'd4) begin
          header_length_next = {header_length_next[7:0], data_byte};
        end else if (header_pos_next < 5'd8) begin
          cookie_shift_next = {cookie_shift_next[23:0], data_byte};
        end
        if (header_pos_next == 5'd7 && cookie_shift_next != stunp_pkg::MAGIC_COOKIE) begin
          phase_next       = PH_IDLE;
          has_res          = 1'b1;
          res.event_res    = stunp_pkg::EV_BAD_COOKIE;
          res.message_done = 1'b1;
        end else if (header_pos_next >= 5'd19) begin
          done                 = (header_length_next == 16'd0);
          phase_next           = done ? PH_IDLE : PH_ATTR_HDR;
          attr_byte_index_next = '0;
          has_res              = 1'b1;
          res.event_res        = stunp_pkg::EV_HEADER;
          res.message_done     = done;
        end
        header_pos_next = header_pos_next + 5'd1;
      end
      PH_ATTR_HDR: begin
        if (attr_byte_index < 17'd2) begin
          cur_attr_type_next = {cur_attr_type[7:0], data_byte};
        end else begin
          cur_attr_length_next = {cur_attr_length[7:0], data_byte};
        end
        if (attr_byte_index >= 17'd3) begin
          attr_byte_index_next = '0;
          addr_family_next     = '0;
          addr_port_next       = '0;
          addr_ip_next         = '0;
          if (cur_attr_length_next == 16'd0) begin
            fin = 1'b1;
          end else begin
            phase_next = PH_ATTR_BODY;
          end
        end else begin
          attr_byte_index_next = idx_inc[16:0];
        end
      end
      PH_ATTR_BODY: begin
        if (attr_byte_index < 17'd2) begin
          addr_family_next = {addr_family[7:0], data_byte};
        end else if (attr_byte_index < 17'd4) begin
          addr_port_next = {addr_port[7:0], data_byte};
        end else if (attr_byte_index < 17'd8) begin
          addr_ip_next = {addr_ip[23:0], data_byte};
        end
        attr_byte_index_next = idx_inc[16:0];
        fin = (idx_inc >= {1'b0, padded});
      end
      default: begin
      end
    endcase

    if (fin) begin
      case (cur_attr_type_next)
        stunp_pkg::ATTR_MAPPED: begin
          is_addr = 1'b1;
          kind    = stunp_pkg::KIND_MAPPED;
        end
        stunp_pkg::ATTR_RESPONSE: begin
          is_addr = 1'b1;
          kind    = stunp_pkg::KIND_RESPONSE;
        end
        stunp_pkg::ATTR_SOURCE: begin
          is_addr = 1'b1;
          kind    = stunp_pkg::KIND_SOURCE;
        end
        stunp_pkg::ATTR_CHANGED: begin
          is_addr = 1'b1;
          kind    = stunp_pkg::KIND_CHANGED;
        end
        stunp_pkg::ATTR_XOR_MAPPED: begin
          is_addr = 1'b1;
          kind    = stunp_pkg::KIND_XOR_MAPPED;
        end
        default: begin
          is_addr = 1'b0;
          kind    = stunp_pkg::KIND_MAPPED;
        end
      endcase
      done                 = ({1'b0, header_length_next} <= body_consumed_next);
      phase_next           = done ? PH_IDLE : PH_ATTR_HDR;
      attr_byte_index_next = '0;
      has_res              = 1'b1;
      res.attr_type        = cur_attr_type_next;
      res.attr_length      = cur_attr_length_next;
      res.message_done     = done;
      if (is_addr && cur_attr_length_next >= 16'd8) begin
        res.event_res   = stunp_pkg::EV_ADDRESS;
        res.addr_kind   = kind;
        res.family_ipv4 = (addr_family_next == 16'd1);
        if (kind == stunp_pkg::KIND_XOR_MAPPED) begin
          res.port       = addr_port_next ^ stunp_pkg::MAGIC_COOKIE[31:16];
          res.ip_address = addr_ip_next ^ stunp_pkg::MAGIC_COOKIE;
        end else begin
          res.port       = addr_port_next;
          res.ip_address = addr_ip_next;
        end
      end else begin
        res.event_res = stunp_pkg::EV_OTHER;
      end
    end

    res.msg_method = header_type_next & ~stunp_pkg::CLASS_MASK;
    res.msg_class  = {header_type_next[8], header_type_next[4]};
    res.msg_length = header_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      header_pos      <= '0;
      header_type     <= '0;
      header_length   <= '0;
      cookie_shift    <= '0;
      body_consumed   <= '0;
      cur_attr_type   <= '0;
      cur_attr_length <= '0;
      attr_byte_index <= '0;
      addr_family     <= '0;
      addr_port       <= '0;
      addr_ip         <= '0;
    end else if (step) begin
      phase           <= phase_next;
      header_pos      <= header_pos_next;
      header_type     <= header_type_next;
      header_length   <= header_length_next;
      cookie_shift    <= cookie_shift_next;
      body_consumed   <= body_consumed_next;
      cur_attr_type   <= cur_attr_type_next;
      cur_attr_length <= cur_attr_length_next;
      attr_byte_index <= attr_byte_index_next;
      addr_family     <= addr_family_next;
      addr_port       <= addr_port_next;
      addr_ip         <= addr_ip_next;
    end
  end

endmodule
